### rtl/rcmi_pkg.sv
`timescale 1ns / 1ps
// shared constants and register codes for the row to column major index converter
package rcmi_pkg;

	// fixed field widths
	localparam int FIELD_BITS     = 32;
	localparam int EXT_BITS       = 16;
	localparam int DIM_COUNT_BITS = 3;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// extents that have a register of their own
	localparam int REG_DIMS = 4;

	// wide enough to count up to the largest dimension limit
	localparam int DIMS_CNT_BITS = 4;

	// default parameter values
	localparam int DEF_MAX_DIMS   = 4;
	localparam int DEF_INDEX_BITS = 32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DIM_COUNT = 3'd0,
		REG_SIZE_DIM0 = 3'd1,
		REG_SIZE_DIM1 = 3'd2,
		REG_SIZE_DIM2 = 3'd3,
		REG_SIZE_DIM3 = 3'd4
	} cfg_reg_t;

endpackage

### rtl/row_to_column_major_index.sv
`timescale 1ns / 1ps
// row-major to column-major flat index converter, pipelined top level
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  cfg       | cfg_wr_en               | cfg_index, cfg_data
//  in        | in_valid / in_stall     | linear_index
//  out       | out_valid / out_stall   | column_index, out_of_range
//
// one index enters every cycle while in_stall is low, then passes through the divide,
// multiply and accumulate stages of every dim and then the two-entry output buffer
// most depth is in the restoring dividers: one quotient bit per stage, one divider per dim
// reset clears the configuration to one dimension of extent one and empties the pipeline
// a two-entry output buffer takes results while out_stall is high; the pipeline only freezes
// when that buffer is full, and in_stall is then raised
module row_to_column_major_index #(
	parameter int MAX_DIMS   = rcmi_pkg::DEF_MAX_DIMS,
	parameter int INDEX_BITS = rcmi_pkg::DEF_INDEX_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_wr_en,
	input  logic [rcmi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rcmi_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// index input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rcmi_pkg::FIELD_BITS-1:0]    linear_index,
	// converted index output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rcmi_pkg::FIELD_BITS-1:0]    column_index,
	output logic                               out_of_range
);

	// each dimension: INDEX_BITS divide steps, a multiply stage and an accumulate stage
	localparam int DIM_STAGES = INDEX_BITS + 2;
	localparam int DEPTH      = MAX_DIMS * DIM_STAGES;
	localparam int EB         = rcmi_pkg::EXT_BITS;
	localparam int CB         = rcmi_pkg::DIMS_CNT_BITS;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [rcmi_pkg::DIM_COUNT_BITS-1:0] dim_count_q;
	logic [EB-1:0]                       size_q [rcmi_pkg::REG_DIMS];
	logic [1:0]                          size_sel;

	assign size_sel = 2'(cfg_index - rcmi_pkg::CFG_IDX_BITS'(rcmi_pkg::REG_SIZE_DIM0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= rcmi_pkg::DIM_COUNT_BITS'(1);
			for (int i = 0; i < rcmi_pkg::REG_DIMS; i++) begin
				size_q[i] <= EB'(1);
			end
		end else if (cfg_wr_en) begin
			case (rcmi_pkg::cfg_reg_t'(cfg_index))
				rcmi_pkg::REG_DIM_COUNT: begin
					dim_count_q <= cfg_data[rcmi_pkg::DIM_COUNT_BITS-1:0];
				end
				rcmi_pkg::REG_SIZE_DIM0, rcmi_pkg::REG_SIZE_DIM1,
				rcmi_pkg::REG_SIZE_DIM2, rcmi_pkg::REG_SIZE_DIM3: begin
					size_q[size_sel] <= cfg_data[EB-1:0];
				end
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// effective dimension count and extents
	// ------------------------------------------------------------------
	logic [CB-1:0] dims_used;
	logic          pass_thru;
	logic [EB-1:0] ext_eff [MAX_DIMS];

	// zero count reads as one, anything above the limit saturates
	always_comb begin
		dims_used = CB'(dim_count_q);
		if (dims_used == '0) begin
			dims_used = CB'(1);
		end else if (dims_used > CB'(MAX_DIMS)) begin
			dims_used = CB'(MAX_DIMS);
		end
	end

	assign pass_thru = dims_used < CB'(2);

	// dims out of use, zero extents and dims without a register all behave as extent one
	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_ext
		if (d < rcmi_pkg::REG_DIMS) begin : g_reg
			assign ext_eff[d] = (CB'(d) < dims_used && size_q[d] != '0) ? size_q[d] : EB'(1);
		end else begin : g_one
			assign ext_eff[d] = EB'(1);
		end
	end

	// column-major strides, kept modulo 2^INDEX_BITS; each register past the first is a multiply
	// of the one before it, settling after a configuration write well before any item needs it
	logic [INDEX_BITS-1:0] stride_q [MAX_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				stride_q[d] <= INDEX_BITS'(1);
			end
		end else begin
			stride_q[0] <= INDEX_BITS'(1);
			for (int d = 1; d < MAX_DIMS; d++) begin
				stride_q[d] <= INDEX_BITS'(stride_q[d-1] * INDEX_BITS'(ext_eff[d-1]));
			end
		end
	end

	// ------------------------------------------------------------------
	// pipeline control: the whole pipeline moves unless the output buffer is full
	// ------------------------------------------------------------------
	logic [1:0] buf_cnt_q;
	logic       adv;

	assign adv      = buf_cnt_q != 2'd2;
	assign in_stall = !adv;

	// ------------------------------------------------------------------
	// pipeline stages
	// dims are taken from the last (fastest in row-major) down to dim zero;
	// work holds the dividend and collects quotient bits, part the partial remainder
	// ------------------------------------------------------------------
	logic                  vld_s  [DEPTH];
	logic [INDEX_BITS-1:0] work_s [DEPTH];
	logic [EB-1:0]         part_s [DEPTH];
	logic [INDEX_BITS-1:0] prod_s [DEPTH];
	logic [INDEX_BITS-1:0] acc_s  [DEPTH];
	logic                  oor_s;

	for (genvar s = 0; s < DEPTH; s++) begin : g_stage
		localparam int K = s / DIM_STAGES;
		localparam int P = s % DIM_STAGES;
		localparam int D = MAX_DIMS - 1 - K;

		logic                  v_i;
		logic [INDEX_BITS-1:0] w_i, pr_i, a_i;
		logic [EB-1:0]         p_i;
		logic [INDEX_BITS-1:0] w_n, pr_n, a_n;
		logic [EB-1:0]         p_n;
		logic [EB-1:0]         p_start;
		logic [EB:0]           trial;

		if (s == 0) begin : g_head
			assign v_i  = in_valid;
			assign w_i  = INDEX_BITS'(linear_index);
			assign p_i  = '0;
			assign pr_i = '0;
			assign a_i  = '0;
		end else begin : g_link
			assign v_i  = vld_s[s-1];
			assign w_i  = work_s[s-1];
			assign p_i  = part_s[s-1];
			assign pr_i = prod_s[s-1];
			assign a_i  = acc_s[s-1];
		end

		// a new division starts from an empty remainder
		assign p_start = (P == 0) ? '0 : p_i;
		assign trial   = {p_start, w_i[INDEX_BITS-1]};

		always_comb begin
			w_n  = w_i;
			p_n  = p_i;
			pr_n = pr_i;
			a_n  = a_i;
			if (P < INDEX_BITS) begin
				// one restoring divide step
				if (trial >= {1'b0, ext_eff[D]}) begin
					p_n = EB'(trial - {1'b0, ext_eff[D]});
					w_n = {w_i[INDEX_BITS-2:0], 1'b1};
				end else begin
					p_n = trial[EB-1:0];
					w_n = {w_i[INDEX_BITS-2:0], 1'b0};
				end
			end else if (P == INDEX_BITS) begin
				// digit times stride; with a single dim the dropped carry is put back instead
				if (D == 0 && pass_thru) begin
					pr_n = INDEX_BITS'(w_i * INDEX_BITS'(ext_eff[0]));
				end else begin
					pr_n = INDEX_BITS'(INDEX_BITS'(p_i) * stride_q[D]);
				end
			end else begin
				if (D == 0 && pass_thru) begin
					a_n = a_i + pr_i + INDEX_BITS'(p_i);
				end else begin
					a_n = a_i + pr_i;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (adv) begin
				vld_s[s] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				work_s[s] <= w_n;
				part_s[s] <= p_n;
				prod_s[s] <= pr_n;
				acc_s[s]  <= a_n;
			end
		end
	end

	// anything left over after dim zero means the index was past the element count
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s <= work_s[DEPTH-2] != '0;
		end
	end

	// ------------------------------------------------------------------
	// two-entry output buffer
	// ------------------------------------------------------------------
	logic [INDEX_BITS-1:0] res_q [2];
	logic                  oor_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic                  push, pop;

	assign push = adv && vld_s[DEPTH-1];
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= 2'd0;
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   buf_cnt_q <= buf_cnt_q + 2'd1;
				2'b01:   buf_cnt_q <= buf_cnt_q - 2'd1;
				default: buf_cnt_q <= buf_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= acc_s[DEPTH-1];
			oor_q[wr_ptr_q] <= oor_s;
		end
	end

	assign out_valid    = buf_cnt_q != 2'd0;
	assign column_index = rcmi_pkg::FIELD_BITS'(res_q[rd_ptr_q]);
	assign out_of_range = oor_q[rd_ptr_q];

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the row to column major index converter
module tb_top;

	localparam int MAX_DIMS        = rcmi_pkg::DEF_MAX_DIMS;
	localparam int LATENCY         = rcmi_pkg::DEF_MAX_DIMS * (rcmi_pkg::DEF_INDEX_BITS + 2) + 1;
	localparam int DRAIN_CYCLES    = LATENCY + 50;
	localparam int RESET_CYCLES    = 9;
	localparam int IDLE_PCT        = 13;
	localparam int HOLD_CYCLES     = 600;
	localparam int FLOOD_ITEMS     = 300;
	localparam int TAIL_ITEMS      = 50;
	localparam int RANDOM_PHASES   = 24;
	localparam int ITEMS_PER_PHASE = 42;
	localparam int MAX_REPORTS     = 10;
	localparam int CYCLE_LIMIT     = 200000;

	typedef struct {
		logic [rcmi_pkg::FIELD_BITS-1:0] linear_index;
		logic [rcmi_pkg::FIELD_BITS-1:0] column_index;
		logic                            out_of_range;
	} column_entry_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_wr_en;
	logic [rcmi_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [rcmi_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic                               in_valid;
	logic                               in_stall;
	logic [rcmi_pkg::FIELD_BITS-1:0]    linear_index;
	logic                               out_valid;
	logic                               out_stall;
	logic [rcmi_pkg::FIELD_BITS-1:0]    column_index;
	logic                               out_of_range;

	// shadow of the shape registers
	logic [rcmi_pkg::DIM_COUNT_BITS-1:0] dim_count_r;
	logic [rcmi_pkg::EXT_BITS-1:0]       extent_r [rcmi_pkg::REG_DIMS];

	column_entry_t pending_columns [$];

	logic       no_idle;
	logic [7:0] hold_token;
	logic [7:0] hold_served;

	int indices_sent;
	int columns_checked;
	int column_mismatches;
	int settings_applied;
	int stalled_offers;
	int cycle_count;

	row_to_column_major_index dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.linear_index (linear_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_index (column_index),
		.out_of_range (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int dims_used();
		int n;
		n = int'(dim_count_r);
		if (n < 1)
			n = 1;
		if (n > MAX_DIMS)
			n = MAX_DIMS;
		return n;
	endfunction

	// a zero extent counts as one, dimensions without a register too
	function automatic logic [63:0] extent_of(input int i);
		if (i >= rcmi_pkg::REG_DIMS || extent_r[i] == '0)
			return 64'd1;
		return 64'(extent_r[i]);
	endfunction

	function automatic logic [63:0] element_count();
		logic [63:0] n_elems;
		int          i;
		n_elems = 64'd1;
		for (i = 0; i < dims_used(); i++)
			n_elems *= extent_of(i);
		return n_elems;
	endfunction

	// split into digits with the last dimension fastest, recombine with the first fastest;
	// the carry past dimension zero is dropped, but a single dimension is passed through whole
	function automatic column_entry_t column_major_of(
		input logic [rcmi_pkg::FIELD_BITS-1:0] idx);
		int            n;
		int            i;
		logic [63:0]   rem;
		logic [63:0]   stride;
		logic [63:0]   acc;
		logic [63:0]   digit [MAX_DIMS];
		column_entry_t entry;
		n      = dims_used();
		rem    = 64'(idx);
		acc    = '0;
		stride = 64'd1;
		if (n < 2) begin
			acc = 64'(idx);
		end else begin
			for (i = n - 1; i >= 0; i--) begin
				digit[i] = rem % extent_of(i);
				rem      = rem / extent_of(i);
			end
			for (i = 0; i < n; i++) begin
				acc    += digit[i] * stride;
				stride *= extent_of(i);
			end
		end
		entry.linear_index = idx;
		entry.column_index = acc[rcmi_pkg::FIELD_BITS-1:0];
		entry.out_of_range = (64'(idx) >= element_count());
		return entry;
	endfunction

	// mostly in range, some at the boundary, some anywhere
	function automatic logic [rcmi_pkg::FIELD_BITS-1:0] pick_index();
		logic [63:0] n_elems;
		int          sel;
		n_elems = element_count();
		sel     = $urandom_range(9);
		if (sel < 6 && n_elems <= 64'h1_0000_0000)
			return rcmi_pkg::FIELD_BITS'(64'($urandom) % n_elems);
		if (sel == 6)
			return rcmi_pkg::FIELD_BITS'(n_elems - 1);
		if (sel == 7)
			return rcmi_pkg::FIELD_BITS'(n_elems);
		return $urandom;
	endfunction

	function automatic logic [rcmi_pkg::CFG_DATA_BITS-1:0] random_extent();
		int sel;
		sel = $urandom_range(19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		if (sel == 2)
			return 16'd1;
		if (sel == 3)
			return rcmi_pkg::CFG_DATA_BITS'($urandom_range(65535));
		if (sel < 12)
			return rcmi_pkg::CFG_DATA_BITS'($urandom_range(8, 2));
		return rcmi_pkg::CFG_DATA_BITS'($urandom_range(300, 2));
	endfunction

	// upper data bits are random; the register keeps only the low three
	function automatic logic [rcmi_pkg::CFG_DATA_BITS-1:0] random_dim_count();
		int sel;
		int dc;
		sel = $urandom_range(11);
		if (sel == 0)
			dc = 0;
		else if (sel == 1)
			dc = 1;
		else if (sel < 4)
			dc = $urandom_range(7, 5);
		else
			dc = $urandom_range(4, 2);
		return {13'($urandom), 3'(dc)};
	endfunction

	task automatic write_reg(input logic [rcmi_pkg::CFG_IDX_BITS-1:0] idx,
	                         input logic [rcmi_pkg::CFG_DATA_BITS-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			rcmi_pkg::REG_DIM_COUNT: begin
				dim_count_r = val[rcmi_pkg::DIM_COUNT_BITS-1:0];
			end
			rcmi_pkg::REG_SIZE_DIM0, rcmi_pkg::REG_SIZE_DIM1,
			rcmi_pkg::REG_SIZE_DIM2, rcmi_pkg::REG_SIZE_DIM3: begin
				extent_r[2'(idx - rcmi_pkg::REG_SIZE_DIM0)] = val;
			end
			default: begin
				// no register here, the write has no effect
			end
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_unused_regs();
		int k;
		for (k = int'(rcmi_pkg::REG_SIZE_DIM3) + 1; k < (1 << rcmi_pkg::CFG_IDX_BITS); k++)
			write_reg(rcmi_pkg::CFG_IDX_BITS'(k),
			          rcmi_pkg::CFG_DATA_BITS'($urandom_range(65535)));
	endtask

	// lowers valid and waits until every transfer has produced its result
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_columns.size() != 0);
	endtask

	task automatic apply_shape(input logic [rcmi_pkg::CFG_DATA_BITS-1:0] dc,
	                           input logic [rcmi_pkg::CFG_DATA_BITS-1:0] s0,
	                           input logic [rcmi_pkg::CFG_DATA_BITS-1:0] s1,
	                           input logic [rcmi_pkg::CFG_DATA_BITS-1:0] s2,
	                           input logic [rcmi_pkg::CFG_DATA_BITS-1:0] s3);
		wait_drained();
		write_reg(rcmi_pkg::REG_DIM_COUNT, dc);
		write_reg(rcmi_pkg::REG_SIZE_DIM0, s0);
		write_reg(rcmi_pkg::REG_SIZE_DIM1, s1);
		write_reg(rcmi_pkg::REG_SIZE_DIM2, s2);
		write_reg(rcmi_pkg::REG_SIZE_DIM3, s3);
		settings_applied++;
	endtask

	task automatic offer_index(input logic [rcmi_pkg::FIELD_BITS-1:0] idx);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		linear_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
		pending_columns.insert(pending_columns.size(), column_major_of(idx));
		indices_sent++;
	endtask

	task automatic test_reset_passthrough();
		offer_index('0);
		offer_index('1);
		offer_index(32'h8000_0001);
		wait_drained();
	endtask

	task automatic test_directed_shapes();
		apply_shape(16'd2, 16'd3, 16'd5, 16'd1, 16'd1);
		offer_index(32'd0);
		offer_index(32'd7);
		offer_index(32'd14);
		offer_index(32'd15);
		offer_index('1);
		// zero count behaves as one dimension
		apply_shape(16'd0, 16'd3, 16'd5, 16'd7, 16'd9);
		offer_index(32'd20);
		// count above the limit saturates
		apply_shape(16'd7, 16'd2, 16'd3, 16'd4, 16'd5);
		offer_index(32'd57);
		offer_index(32'd119);
		offer_index(32'd120);
		// zero extents behave as one
		apply_shape(16'd3, 16'd0, 16'd4, 16'd0, 16'd1);
		offer_index(32'd3);
		offer_index(32'd4);
		apply_shape(16'd4, '1, '1, '1, '1);
		offer_index('0);
		offer_index('1);
		offer_index(32'd65534);
		offer_index(32'd65535);
		apply_shape(16'd1, 16'd10, 16'd1, 16'd1, 16'd1);
		offer_index(32'd9);
		offer_index(32'd10);
		// writes past the last register must leave the shape alone
		apply_shape(16'd2, 16'd4, 16'd6, 16'd1, 16'd1);
		write_unused_regs();
		offer_index(32'd23);
		offer_index(32'd24);
		wait_drained();
	endtask

	task automatic test_random_shapes();
		int phase;
		int k;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			no_idle <= (phase >= 8 && phase < 12);
			apply_shape(random_dim_count(), random_extent(), random_extent(),
			            random_extent(), random_extent());
			if (phase % 4 == 1)
				write_unused_regs();
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				offer_index(pick_index());
		end
		wait_drained();
	endtask

	// receiver holds off while the sender floods; after the flood drains the sender sends a tail
	task automatic test_backpressure();
		int k;
		apply_shape(16'd3, 16'd5, 16'd7, 16'd11, 16'd1);
		no_idle    <= 1'b1;
		hold_token <= hold_token + 8'd1;
		for (k = 0; k < FLOOD_ITEMS; k++)
			offer_index(pick_index());
		wait_drained();
		no_idle <= 1'b0;
		for (k = 0; k < TAIL_ITEMS; k++)
			offer_index(pick_index());
		wait_drained();
	endtask

	// receiver side: random stalls, plus one long hold when asked
	initial begin
		out_stall   <= 1'b0;
		hold_served = '0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_served) begin
				hold_served = hold_token;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_columns
		column_entry_t want;
		if (arst_n && in_valid && in_stall)
			stalled_offers++;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_columns.size() == 0) begin
				column_mismatches++;
				if (column_mismatches <= MAX_REPORTS)
					$display("unexpected transfer: column %h out_of_range %b",
					         column_index, out_of_range);
			end else begin
				want = pending_columns.pop_front();
				columns_checked++;
				if (column_index !== want.column_index ||
				    out_of_range !== want.out_of_range) begin
					column_mismatches++;
					if (column_mismatches <= MAX_REPORTS)
						$display("mismatch for index %h: want %h/%b, got %h/%b",
						         want.linear_index, want.column_index,
						         want.out_of_range, column_index, out_of_range);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, pending_columns.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= rcmi_pkg::REG_DIM_COUNT;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		linear_index <= '0;
		no_idle      <= 1'b0;
		hold_token   <= '0;
		dim_count_r  = 3'd1;
		for (i = 0; i < rcmi_pkg::REG_DIMS; i++)
			extent_r[i] = 16'd1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_directed_shapes();
		test_random_shapes();
		test_backpressure();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d index transfers over %0d shapes, input held off on %0d cycles",
		         indices_sent, settings_applied, stalled_offers);
		$display("%0d results compared, %0d mismatches, %0d never arrived",
		         columns_checked, column_mismatches, pending_columns.size());
		if (column_mismatches == 0 && pending_columns.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
